// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the active-low reset is low.
`define B2D_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b2d checker: property failed");

// Same, on the usual clock and reset names.
`define B2D_ASSERT_CLK(lbl, prop) `B2D_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// File: hw/rtl/b2d_pkg.sv
`default_nettype none

package b2d_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam logic [5:0]  ASCII_ZERO     = 6'd48;
  localparam int unsigned Q_DEPTH        = 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } b2d_front_e;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } b2d_back_e;

  typedef struct packed {
    logic full;
    logic empty;
  } b2d_qstat_t;

  // Number of decimal digits of the largest value that fits in the given width.
  function automatic int unsigned num_digits(int unsigned bits);
    logic [71:0] max_v;
    logic [71:0] pow;
    int unsigned n;
    max_v = (72'd1 << bits) - 72'd1;
    pow   = 72'd1;
    n     = 0;
    for (int i = 0; i < 20; i++) begin
      if (pow <= max_v) begin
        n   = n + 1;
        pow = pow * 72'd10;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b2d_fifo.sv
`default_nettype none

module b2d_fifo
  import b2d_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic         pop_i,
  output logic      [W-1:0] rdata_o,
  output b2d_qstat_t        stat_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [W-1:0]     mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (count_q == CNT_W'(Q_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rdata_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b2d_front.sv
`default_nettype none

module b2d_front
  import b2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned NDIG       = num_digits(VALUE_BITS),
  parameter int unsigned IDX_W      = $clog2(NDIG)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire b2d_qstat_t            q_stat_i,
  output logic                       q_push_o,
  output logic      [4*NDIG-1:0]     q_bcd_o,
  output logic      [IDX_W-1:0]      q_top_o
);

  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  b2d_front_e            state_q, state_d;
  logic [VALUE_BITS-1:0] shift_q;
  logic [BCD_W-1:0]      bcd_q;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt_q;
  logic                  accept;

  assign accept = push_i && !full_o;

  always_comb begin
    logic [3:0] dig;
    dig = '0;
    adj = '0;
    for (int i = 0; i < NDIG; i++) begin
      dig = bcd_q[i*4 +: 4];
      adj[i*4 +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    q_top_o = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        q_top_o = IDX_W'(i);
      end
    end
  end

  assign q_bcd_o = bcd_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          state_d = F_CONV;
        end
      end
      F_CONV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_stat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    full_o   = 1'b1;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: full_o = 1'b0;
      F_CONV: full_o = 1'b1;
      F_PUSH: q_push_o = !q_stat_i.full;
      default: full_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      shift_q <= value_i;
      bcd_q   <= '0;
      cnt_q   <= CNT_W'(VALUE_BITS);
    end else if (state_q == F_CONV) begin
      shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
      bcd_q   <= {adj[BCD_W-2:0], shift_q[VALUE_BITS-1]};
      cnt_q   <= cnt_q - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b2d_back.sv
`default_nettype none

module b2d_back
  import b2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned NDIG       = num_digits(VALUE_BITS),
  parameter int unsigned IDX_W      = $clog2(NDIG)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire b2d_qstat_t        q_stat_i,
  output logic                   q_pop_o,
  input  wire logic [4*NDIG-1:0] q_bcd_i,
  input  wire logic [IDX_W-1:0]  q_top_i,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic      [5:0]        digit_char_o,
  output logic                   is_last_o
);

  b2d_back_e         state_q, state_d;
  logic [4*NDIG-1:0] digits_q;
  logic [IDX_W-1:0]  idx_q;
  logic [3:0]        cur_digit;
  logic              out_valid_q, out_valid_d;
  logic [5:0]        out_char_q;
  logic              out_last_q;
  logic              slot_free;
  logic              emit;

  assign slot_free = !out_valid_q || pop_i;
  assign cur_digit = digits_q[idx_q*4 +: 4];

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (slot_free && (idx_q == '0)) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    emit    = 1'b0;
    case (state_q)
      B_IDLE: q_pop_o = !q_stat_i.empty;
      B_EMIT: emit = slot_free;
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      digits_q <= q_bcd_i;
      idx_q    <= q_top_i;
    end else if (emit) begin
      idx_q <= idx_q - IDX_W'(1);
    end
    if (emit) begin
      out_char_q <= ASCII_ZERO + {2'b00, cur_digit};
      out_last_q <= (idx_q == '0);
    end
  end

  assign empty_o      = !out_valid_q;
  assign digit_char_o = out_char_q;
  assign is_last_o    = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
// Input queue side: value_i is taken when push_i is high and full_o is low.
// Result queue side: while empty_o is low, digit_char_o holds the oldest
// waiting ASCII digit and is_last_o marks the final digit of a number; it
// is taken when pop_i is high. Digits come most significant first, with no
// leading zeros, and zero gives the single character '0'.
// The front end converts with a shift-add-3 loop, one input bit per cycle,
// so it holds full_o high from each accepted item until the conversion is
// done and the result is pushed, and takes no new item before then.
// A two-entry queue separates it from the back end, which loads an item
// and then gives one digit per cycle while the result side keeps taking them.
// Each item passes the conversion, the queue and the back end's output register.
// While pop_i stays low the current digit holds; the back end and then the
// queue fill, and the front end then keeps full_o high past its conversion
// until the queue has room again.
// Reset clears all control state and leaves both queues empty.
`default_nettype none

module binary_to_decimal_ascii
  import b2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic      [5:0]            digit_char_o,
  output logic                       is_last_o
);

  localparam int unsigned NDIG  = num_digits(VALUE_BITS);
  localparam int unsigned IDX_W = $clog2(NDIG);
  localparam int unsigned BCD_W = 4 * NDIG;
  localparam int unsigned ENT_W = BCD_W + IDX_W;

  b2d_qstat_t       q_stat;
  logic             q_push;
  logic             q_pop;
  logic [BCD_W-1:0] f_bcd;
  logic [IDX_W-1:0] f_top;
  logic [ENT_W-1:0] q_rdata;

  b2d_front #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .full_o  (full_o),
    .value_i (value_i),
    .q_stat_i(q_stat),
    .q_push_o(q_push),
    .q_bcd_o (f_bcd),
    .q_top_o (f_top)
  );

  b2d_fifo #(
    .W(ENT_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i({f_bcd, f_top}),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .stat_o (q_stat)
  );

  b2d_back #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_pop_o     (q_pop),
    .q_bcd_i     (q_rdata[ENT_W-1:IDX_W]),
    .q_top_i     (q_rdata[IDX_W-1:0]),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .digit_char_o(digit_char_o),
    .is_last_o   (is_last_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/b2d_checker.sv
`default_nettype none
`include "assert_macros.svh"

module b2d_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push_i,
  input wire logic       full_i,
  input wire logic       pop_i,
  input wire logic       empty_i,
  input wire logic [5:0] digit_char_i,
  input wire logic       is_last_i
);

  logic first_q, first_d;

  // Set when the next item on the result side opens a new number.
  always_comb begin
    first_d = first_q;
    if (pop_i && !empty_i) begin
      first_d = is_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else begin
      first_q <= first_d;
    end
  end

  `B2D_ASSERT_CLK(a_digit_range, !empty_i |-> (digit_char_i >= 6'd48) && (digit_char_i <= 6'd57))
  `B2D_ASSERT_CLK(a_result_holds, (!empty_i && !pop_i) |=> (!empty_i && $stable(digit_char_i) && $stable(is_last_i)))
  `B2D_ASSERT_CLK(a_busy_after_accept, (push_i && !full_i) |=> full_i)
  `B2D_ASSERT_CLK(a_no_leading_zero, (!empty_i && first_q && (digit_char_i == 6'd48)) |-> is_last_i)

endmodule

bind binary_to_decimal_ascii b2d_checker u_b2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push_i      (push_i),
  .full_i      (full_o),
  .pop_i       (pop_i),
  .empty_i     (empty_o),
  .digit_char_i(digit_char_o),
  .is_last_i   (is_last_o)
);

`default_nettype wire

// File: sim/b2d_digit_checker.sv
module b2d_digit_checker
  import b2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  pop_i,
  input  logic                  empty_i,
  input  logic [5:0]            digit_char_i,
  input  logic                  is_last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [5:0] digit_char;
    logic       is_last;
  } digit_item_t;

  digit_item_t digit_q [$];
  int          fails = 0;

  // Splits the number into decimal digits and queues their characters,
  // most significant first.
  task automatic expand_value(input logic [VALUE_BITS-1:0] v);
    logic [3:0]            dec_digits [20];
    logic [VALUE_BITS-1:0] rem;
    int                    n;
    digit_item_t           item;
    rem = v;
    n   = 0;
    do begin
      dec_digits[n] = 4'(rem % 10);
      rem           = rem / 10;
      n++;
    end while (rem != 0);
    for (int k = n - 1; k >= 0; k--) begin
      item.digit_char = ASCII_ZERO + 6'(dec_digits[k]);
      item.is_last    = (k == 0);
      digit_q.push_back(item);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digit_item_t want;
    if (!rst_ni) begin
      digit_q.delete();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (digit_q.size() == 0) begin
          $error("digit_char: no item expected, actual %0d", digit_char_i);
          fails++;
        end else begin
          want = digit_q.pop_front();
          if (digit_char_i !== want.digit_char) begin
            $error("digit_char: expected %0d, actual %0d", want.digit_char, digit_char_i);
            fails++;
          end
          if (is_last_i !== want.is_last) begin
            $error("is_last: expected %0d, actual %0d", want.is_last, is_last_i);
            fails++;
          end
        end
      end
      if (push_i && !full_i) begin
        expand_value(value_i);
      end
      pending_o    <= digit_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  import b2d_pkg::*;

  localparam int unsigned   VB               = VALUE_BITS_DEF;
  localparam logic [VB-1:0] VALUE_MAX        = '1;
  localparam int            CYCLE_LIMIT      = 1000000;
  localparam int            DRAIN_CYCLES     = 80;
  localparam int            HOLD_CYCLES      = 400;
  localparam int            RANDOM_PER_PHASE = 75;

  logic          clk_i;
  logic          rst_ni;
  logic          push_i;
  logic          full_o;
  logic [VB-1:0] value_i;
  logic          pop_i;
  logic          empty_o;
  logic [5:0]    digit_char_o;
  logic          is_last_o;

  int fail_count;
  int pending_digits;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_req;
  int hold_taken;
  int hold_left;
  int cycle_count = 0;

  int unsigned directed_vals [25] = '{
    0, 1, 9, 10, 11, 99, 100, 101, 999, 1000, 9999, 10000, 99999, 100000,
    999999, 1000000, 9999999, 10000000, 99999999, 100000000, 999999999,
    1000000000, 2147483647, 1431655765, 715827882
  };

  binary_to_decimal_ascii #(
    .VALUE_BITS(VB)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .value_i      (value_i),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .digit_char_o (digit_char_o),
    .is_last_o    (is_last_o)
  );

  b2d_digit_checker #(
    .VALUE_BITS(VB)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .value_i      (value_i),
    .pop_i        (pop_i),
    .empty_i      (empty_o),
    .digit_char_i (digit_char_o),
    .is_last_i    (is_last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_digits)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    pop_i      = 1'b0;
    hold_taken = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_taken) begin
        hold_taken = hold_req;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [VB-1:0] pick_value();
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    case ($urandom_range(3))
      0: return VB'($urandom);
      1: return VB'($urandom_range(9));
      default: begin
        ndig = $urandom_range(10, 1);
        lo   = 1;
        repeat (ndig - 1) lo = lo * 10;
        hi = (ndig == 10) ? 32'(VALUE_MAX) : lo * 10 - 1;
        if (ndig == 1) begin
          lo = 0;
        end
        return VB'($urandom_range(hi, lo));
      end
    endcase
  endfunction

  task automatic send_value(input logic [VB-1:0] v);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      if ($urandom_range(99) < tx_idle_pct) begin
        push_i <= 1'b0;
        @(negedge clk_i);
      end else begin
        push_i  <= 1'b1;
        value_i <= v;
        @(posedge clk_i);
        taken = !full_o;
        @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    @(negedge clk_i);
    while (pending_digits != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    push_i       = 1'b0;
    value_i      = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_vals[i]) begin
      send_value(VB'(directed_vals[i]));
    end
    wait_drained();

    // The result side holds off while items keep coming, so the block fills up.
    hold_req = 1;
    repeat (16) send_value(pick_value());
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 88;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 88;
        end
        default: begin
          tx_idle_pct  = 10;
          rx_stall_pct = 10;
        end
      endcase
      repeat (RANDOM_PER_PHASE) send_value(pick_value());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
